@@ rtl/cartridge_bank_controller_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cartridge bank controller checks
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define CBC_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("cartridge bank controller check failed");

// Next-cycle implication.
`define CBC_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("cartridge bank controller check failed");

`endif

@@ rtl/cbc_pkg.sv @@
// ---------------------------------------------------------------------------
// cbc_pkg
// Shared widths, mapper and target codes, and types of the bank controller.
// ---------------------------------------------------------------------------
package cbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 3;
    localparam int TGT_W      = 3;
    localparam int ROM_W      = 23;
    localparam int RAM_W      = 17;
    localparam int ROM_BANK_W = 9;
    localparam int RAM_BANK_W = 8;

    localparam logic [MAP_W-1:0] MAP_NONE = 3'd0;
    localparam logic [MAP_W-1:0] MAP_MBC1 = 3'd1;
    localparam logic [MAP_W-1:0] MAP_MBC2 = 3'd2;
    localparam logic [MAP_W-1:0] MAP_MBC3 = 3'd3;
    localparam logic [MAP_W-1:0] MAP_MBC5 = 3'd4;

    localparam logic [TGT_W-1:0] TGT_ROM     = 3'd0;
    localparam logic [TGT_W-1:0] TGT_RAM     = 3'd1;
    localparam logic [TGT_W-1:0] TGT_BLOCKED = 3'd2;
    localparam logic [TGT_W-1:0] TGT_PASS    = 3'd3;
    localparam logic [TGT_W-1:0] TGT_CTRL    = 3'd4;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enable;
        logic                  banking_mode;
    } t_bank_state;

    typedef struct packed {
        logic [TGT_W-1:0]      target;
        logic [ROM_W-1:0]      rom_address;
        logic [RAM_W-1:0]      ram_address;
        logic                  ram_enabled;
        logic [ROM_BANK_W-1:0] rom_bank_now;
        logic [RAM_BANK_W-1:0] ram_bank_now;
    } t_result;

endpackage

@@ rtl/cbc_decode.sv @@
// ---------------------------------------------------------------------------
// cbc_decode
// Decode one bus request: next bank registers and the translated result.
// ---------------------------------------------------------------------------
module cbc_decode import cbc_pkg::*; #(
    parameter int ROM_ADDR_BITS = 23,
    parameter int RAM_BANKS     = 16
) (
    input  logic [MAP_W-1:0]  i_mapper_type,
    input  t_bank_state       i_state,
    input  logic              i_opcode,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [DATA_W-1:0] i_write_data,
    output t_bank_state       o_state,
    output t_result           o_result
);

    localparam logic [ROM_W-1:0] ROM_MASK =
        ROM_W'((32'd1 << ROM_ADDR_BITS) - 32'd1);
    localparam logic [RAM_BANK_W-1:0] RAM_LIMIT = RAM_BANK_W'(RAM_BANKS);

    // A bank whose low five bits are zero steps up by one.
    function automatic logic [ROM_BANK_W-1:0] fix_low_zero(
        input logic [ROM_BANK_W-1:0] bank
    );
        logic [ROM_BANK_W-1:0] fixed;
        fixed = bank;
        if (bank[4:0] == 5'd0) begin
            fixed[4:0] = 5'd1;
        end
        return fixed;
    endfunction

    logic                  is_mbc1, is_mbc2, is_mbc3, is_mbc5;
    logic [ROM_BANK_W-1:0] read_bank;
    logic [TGT_W-1:0]      target;
    logic [ROM_W-1:0]      rom_address;
    logic [RAM_W-1:0]      ram_address;
    t_bank_state           n_state;

    assign is_mbc1 = (i_mapper_type == MAP_MBC1);
    assign is_mbc2 = (i_mapper_type == MAP_MBC2);
    assign is_mbc3 = (i_mapper_type == MAP_MBC3);
    assign is_mbc5 = (i_mapper_type == MAP_MBC5);

    assign read_bank = i_address[14] ? i_state.rom_bank : '0;

    always_comb begin
        n_state     = i_state;
        target      = TGT_PASS;
        rom_address = '0;
        ram_address = '0;
        if (!i_address[15]) begin
            if (i_opcode) begin
                target = TGT_CTRL;
                unique case (i_address[14:13])
                    2'b00: begin
                        if (!(is_mbc2 && i_address[8])) begin
                            n_state.ram_enable = i_write_data[3] & i_write_data[1];
                        end
                    end
                    2'b01: begin
                        priority if (is_mbc1 || is_mbc2) begin
                            n_state.rom_bank = fix_low_zero({1'b0, i_state.rom_bank[7:5],
                                                             i_write_data[4:0]});
                        end else if (is_mbc3) begin
                            n_state.rom_bank = (i_write_data[6:0] == 7'd0) ?
                                               ROM_BANK_W'(1) : {2'b00, i_write_data[6:0]};
                        end else if (is_mbc5) begin
                            if (!i_address[12]) begin
                                n_state.rom_bank = {i_state.rom_bank[8], i_write_data};
                            end else begin
                                n_state.rom_bank = {i_write_data[0], i_state.rom_bank[7:0]};
                            end
                        end else begin
                            n_state.rom_bank = i_state.rom_bank;
                        end
                    end
                    2'b10: begin
                        priority if (is_mbc1) begin
                            if (i_state.banking_mode) begin
                                n_state.ram_bank = {6'd0, i_write_data[1:0]};
                            end else begin
                                n_state.rom_bank = fix_low_zero({2'b00, i_write_data[1:0],
                                                                 i_state.rom_bank[4:0]});
                            end
                        end else if (is_mbc3 || is_mbc5) begin
                            n_state.ram_bank = i_write_data;
                        end else begin
                            n_state.ram_bank = i_state.ram_bank;
                        end
                    end
                    default: begin
                        if (is_mbc1 || is_mbc2) begin
                            n_state.banking_mode = i_write_data[0];
                        end
                    end
                endcase
            end else begin
                target      = TGT_ROM;
                rom_address = {read_bank, i_address[13:0]} & ROM_MASK;
            end
        end else if (i_address[15:13] == 3'b101) begin
            priority if (!i_state.ram_enable) begin
                target = TGT_PASS;
            end else if ((is_mbc3 && i_state.ram_bank > 8'd3) ||
                         i_state.ram_bank >= RAM_LIMIT) begin
                target = TGT_BLOCKED;
            end else begin
                target      = TGT_RAM;
                ram_address = {i_state.ram_bank[3:0], i_address[12:0]};
            end
        end
    end

    assign o_state              = n_state;
    assign o_result.target      = target;
    assign o_result.rom_address = rom_address;
    assign o_result.ram_address = ram_address;
    assign o_result.ram_enabled = n_state.ram_enable;
    assign o_result.rom_bank_now = n_state.rom_bank;
    assign o_result.ram_bank_now = n_state.ram_bank;

endmodule

@@ rtl/cartridge_bank_controller.sv @@
// ---------------------------------------------------------------------------
// cartridge_bank_controller
// Bank register file and address translation for MBC1/2/3/5 cartridges.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+----------------------------------
//  config   | i_cfg_we                   | i_cfg_wdata (mapper type)
//  request  | i_in_valid / o_in_ready    | i_opcode, i_address, i_write_data
//  result   | o_out_valid / i_out_ready  | o_target, o_rom_address, ...
//
//  One request per cycle while o_in_ready is high. The decode is a single
//  pass from the request ports into the result register, or into the skid
//  while an earlier result waits; the bank registers update at the same edge.
//  A two-entry output (result register plus skid) keeps o_in_ready high
//  while one result waits; it drops only when both entries are full.
//  Synchronous active-low reset: rom bank 1, ram bank 0, ram disabled,
//  mode 0, mapper none, output empty.
//
module cartridge_bank_controller import cbc_pkg::*; #(
    parameter int ROM_ADDR_BITS = 23,
    parameter int RAM_BANKS     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [MAP_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [DATA_W-1:0]     i_write_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [TGT_W-1:0]      o_target,
    output logic [ROM_W-1:0]      o_rom_address,
    output logic [RAM_W-1:0]      o_ram_address,
    output logic                  o_ram_enabled,
    output logic [ROM_BANK_W-1:0] o_rom_bank_now,
    output logic [RAM_BANK_W-1:0] o_ram_bank_now
);

    logic [MAP_W-1:0] r_mapper_type;
    t_bank_state      r_state, n_state, dec_state;
    t_result          dec_result;
    t_result          r_out, n_out;
    t_result          r_skid, n_skid;
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    logic             accept, take;

    cbc_decode #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .RAM_BANKS     (RAM_BANKS)
    ) u_decode (
        .i_mapper_type (r_mapper_type),
        .i_state       (r_state),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_state       (dec_state),
        .o_result      (dec_result)
    );

    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign take       = r_out_valid && i_out_ready;

    // Commit bank register updates only for an accepted request.
    assign n_state = accept ? dec_state : r_state;

    // Output queue: the result register drains first, the skid backs it up.
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (take) begin
            if (r_skid_valid) begin
                // skid full means no request is accepted this cycle
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = accept;
                if (accept) begin
                    n_out = dec_result;
                end
            end
        end else if (accept) begin
            if (!r_out_valid) begin
                n_out       = dec_result;
                n_out_valid = 1'b1;
            end else begin
                // result still waiting: park the new one
                n_skid       = dec_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_type        <= MAP_NONE;
            r_state.rom_bank     <= ROM_BANK_W'(1);
            r_state.ram_bank     <= '0;
            r_state.ram_enable   <= 1'b0;
            r_state.banking_mode <= 1'b0;
            r_out_valid          <= 1'b0;
            r_skid_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mapper_type <= i_cfg_wdata;
            end
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_target       = r_out.target;
    assign o_rom_address  = r_out.rom_address;
    assign o_ram_address  = r_out.ram_address;
    assign o_ram_enabled  = r_out.ram_enabled;
    assign o_rom_bank_now = r_out.rom_bank_now;
    assign o_ram_bank_now = r_out.ram_bank_now;

endmodule

@@ rtl/cbc_checker.sv @@
// ---------------------------------------------------------------------------
// cbc_checker
// Port-level checks of the cartridge bank controller, bound to the top.
// ---------------------------------------------------------------------------
`include "cartridge_bank_controller_macros.svh"

module cbc_checker import cbc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [TGT_W-1:0]      o_target,
    input logic [ROM_W-1:0]      o_rom_address,
    input logic [RAM_W-1:0]      o_ram_address,
    input logic                  o_ram_enabled
);

    // A stalled result holds.
    `CBC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_target) && $stable(o_rom_address) && $stable(o_ram_address))

    // Backpressure on requests only when a result is already waiting.
    `CBC_ASSERT_IMP(a_ready_low_needs_result, !o_in_ready, o_out_valid)

    // Only the selected translation carries an address.
    `CBC_ASSERT_IMP(a_rom_addr_zero, o_out_valid && o_target != TGT_ROM, o_rom_address == '0)
    `CBC_ASSERT_IMP(a_ram_hit_enabled, o_out_valid && o_target == TGT_RAM, o_ram_enabled)

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);
